// ----- hdl/ped_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned MAX_COLORS_DEF = 16;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned NCH    = 3;
  localparam int unsigned ERR_W  = 9;
  localparam int unsigned ROW_W  = NCH * ERR_W;
  localparam int unsigned DIST_W = 18;

  // Stream and configuration port widths.
  localparam int unsigned TDATA_W    = 32;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned PSIZE_W    = 5;
  localparam int unsigned LWIDTH_W   = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b1;

  // Input word kinds.
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  typedef logic [CH_W-1:0]         pix_t;
  typedef pix_t [NCH-1:0]          pix3_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic  done;
    pix3_t color;
  } search_rsp_t;

  function automatic pix_t clamp8(input logic signed [10:0] v);
    pix_t r;
    if (v < 11'sd0) begin
      r = '0;
    end else if (v > 11'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Divide by 16, rounding toward zero.
  function automatic err_t div16_tz(input logic signed [12:0] v);
    logic signed [12:0] b;
    b = v + (v[12] ? 13'sd15 : 13'sd0);
    return b[12:4];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ped_row_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ped_row_store #(
  parameter int unsigned DEPTH = ped_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WIDTH = ped_pkg::ROW_W
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/ped_palette.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ped_palette #(
  parameter int unsigned MAX_COLORS = ped_pkg::MAX_COLORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [$clog2(MAX_COLORS)-1:0]   wr_addr_i,
  input  ped_pkg::pix3_t                  wr_data_i,
  input  logic                            start_i,
  input  logic [$clog2(MAX_COLORS+1)-1:0] count_i,
  input  ped_pkg::pix3_t                  pix_i,
  output logic [$clog2(MAX_COLORS)-1:0]   label_o,
  output ped_pkg::search_rsp_t            rsp_o
);

  localparam int unsigned PIDX_W = $clog2(MAX_COLORS);

  ped_pkg::pix3_t mem [MAX_COLORS];

  logic                          iss_q;
  logic [PIDX_W-1:0]             iss_idx_q;
  logic [PIDX_W-1:0]             last_idx;

  logic                          rd_v_q;
  logic                          rd_last_q;
  logic [PIDX_W-1:0]             rd_idx_q;
  ped_pkg::pix3_t                rd_data_q;

  logic                          dist_v_q;
  logic                          dist_last_q;
  logic [PIDX_W-1:0]             dist_idx_q;
  ped_pkg::pix3_t                dist_col_q;
  logic [ped_pkg::DIST_W-1:0]    dist_q;
  logic [ped_pkg::DIST_W-1:0]    dist_d;

  logic                          done_q;
  logic [PIDX_W-1:0]             best_q;
  logic [ped_pkg::DIST_W-1:0]    best_d_q;
  ped_pkg::pix3_t                best_col_q;

  assign last_idx = PIDX_W'(count_i - 1'b1);

  // Palette store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (iss_q) begin
      rd_data_q <= mem[iss_idx_q];
    end
  end

  // Squared distance of the entry just read.
  always_comb begin
    logic signed [8:0] diff;
    logic [15:0]       sq;
    dist_d = '0;
    for (int k = 0; k < ped_pkg::NCH; k++) begin
      diff   = $signed({1'b0, pix_i[k]}) - $signed({1'b0, rd_data_q[k]});
      sq     = 16'(diff * diff);
      dist_d = dist_d + ped_pkg::DIST_W'(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q    <= 1'b0;
      rd_v_q   <= 1'b0;
      dist_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (start_i) begin
        iss_q <= 1'b1;
      end else if (iss_q && (iss_idx_q == last_idx)) begin
        iss_q <= 1'b0;
      end
      rd_v_q   <= iss_q;
      dist_v_q <= rd_v_q;
      done_q   <= dist_v_q && dist_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      iss_idx_q <= '0;
    end else if (iss_q) begin
      iss_idx_q <= iss_idx_q + 1'b1;
    end
    rd_idx_q    <= iss_idx_q;
    rd_last_q   <= (iss_idx_q == last_idx);
    dist_idx_q  <= rd_idx_q;
    dist_last_q <= rd_last_q;
    dist_col_q  <= rd_data_q;
    dist_q      <= dist_d;
    // Strict compare keeps the lower index on a tie.
    if (dist_v_q && ((dist_idx_q == '0) || (dist_q < best_d_q))) begin
      best_q     <= dist_idx_q;
      best_d_q   <= dist_q;
      best_col_q <= dist_col_q;
    end
  end

  assign label_o     = best_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.color = best_col_q;

  a_done_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_v_q && dist_last_q) |=> done_q)
    else $error("search done missing after last entry");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!iss_q && !rd_v_q && !dist_v_q))
    else $error("search restarted while running");

  a_no_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (!iss_q && !start_i))
    else $error("palette written during search");

endmodule

`default_nettype wire

// ----- hdl/palette_error_diffusion_dither.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: entry_index, chan_a, chan_b, chan_c
//                                                    tuser: opcode, frame_start
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: label, out_a, out_b, out_c
//                                                    tlast: row_end
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A palette word is written from idle. A pixel steps through the adjust, search, diffusion,
// write-back and output states, with one more write on the last column of a row; the
// palette search reads one entry per cycle from the palette memory. A new word is taken
// once the previous pixel sits in the output register, so a stalled output stalls input
// only when a second result is ready. Reset returns tracking to the start of a first row;
// both stores come up unwritten and need no clearing pass. Configuration is always ready.

module palette_error_diffusion_dither #(
  parameter int unsigned MAX_COLORS = ped_pkg::MAX_COLORS_DEF,
  parameter int unsigned MAX_WIDTH  = ped_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] entry_index, [11:4] chan_a, [19:12] chan_b, [27:20] chan_c, [31:28] zero
  input  logic [ped_pkg::TDATA_W-1:0]       s_axis_tdata,
  // [0] opcode, [1] frame_start
  input  logic [ped_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // Result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] label, [11:4] out_a, [19:12] out_b, [27:20] out_c, [31:28] zero
  output logic [ped_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tlast,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ped_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ped_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PIDX_W = $clog2(MAX_COLORS);
  localparam int unsigned CNT_W  = $clog2(MAX_COLORS + 1);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ERR_W  = ped_pkg::ERR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_SEARCH,
    ST_DIFF,
    ST_WR_PREV,
    ST_WR_LAST,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers and their clamped views.
  logic [ped_pkg::PSIZE_W-1:0]  psize_q;
  logic [ped_pkg::LWIDTH_W-1:0] lwidth_q;
  logic [CNT_W-1:0]             n_eff;
  logic [COL_W-1:0]             w_last;

  // Row tracking state.
  logic                         first_row_q;
  logic [COL_W-1:0]             col_q;
  ped_pkg::err_t                left_q  [ped_pkg::NCH];
  ped_pkg::err_t                part0_q [ped_pkg::NCH];
  ped_pkg::err_t                part1_q [ped_pkg::NCH];

  // Per-pixel working registers.
  ped_pkg::pix3_t               px_q;
  logic [COL_W-1:0]             cur_col_q;
  logic                         is_last_q;
  logic [PIDX_W-1:0]            lbl_q;
  ped_pkg::pix3_t               pal_q;
  ped_pkg::err_t                prev_wr_q [ped_pkg::NCH];

  // Output register.
  logic                         m_valid_q;
  logic [3:0]                   out_lbl_q;
  ped_pkg::pix3_t               out_col_q;
  logic                         out_last_q;

  // Input word fields.
  logic                         in_acc;
  logic                         pix_acc;
  logic                         frame_start;
  logic [ped_pkg::IDX_W-1:0]    entry_idx;
  ped_pkg::pix3_t               in_pix;
  logic [COL_W-1:0]             col_eff;

  logic                         out_load;

  // Palette search interface.
  logic                         pal_wr_en;
  logic                         srch_start;
  logic [PIDX_W-1:0]            srch_label;
  ped_pkg::search_rsp_t         srch_rsp;

  // Row error store interface.
  logic                         rs_rd_en;
  logic                         rs_wr_en;
  logic [COL_W-1:0]             rs_wr_addr;
  logic [ped_pkg::ROW_W-1:0]    rs_rd_data;
  logic [ped_pkg::ROW_W-1:0]    rs_wr_data;

  // Combinational datapath results.
  ped_pkg::pix3_t               px_adj;
  ped_pkg::err_t                s7      [ped_pkg::NCH];
  ped_pkg::err_t                s1      [ped_pkg::NCH];
  ped_pkg::err_t                prev_wr_d [ped_pkg::NCH];
  ped_pkg::err_t                part0_d [ped_pkg::NCH];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_acc       = in_acc && (s_axis_tuser[0] == ped_pkg::OP_PIXEL);
  assign frame_start   = s_axis_tuser[1];
  assign entry_idx     = s_axis_tdata[3:0];
  assign in_pix[0]     = s_axis_tdata[11:4];
  assign in_pix[1]     = s_axis_tdata[19:12];
  assign in_pix[2]     = s_axis_tdata[27:20];

  // Clamp the registers into the ranges the hardware holds.
  assign n_eff  = (psize_q == '0) ? CNT_W'(1) :
                  (32'(psize_q) > MAX_COLORS) ? CNT_W'(MAX_COLORS) : CNT_W'(psize_q);
  assign w_last = (lwidth_q == '0) ? '0 :
                  (32'(lwidth_q) > MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) :
                  COL_W'(lwidth_q - 1'b1);

  // Column used for this pixel; a narrowed row ends at its new last column.
  assign col_eff = frame_start ? '0 : ((col_q > w_last) ? w_last : col_q);

  assign pal_wr_en  = in_acc && (s_axis_tuser[0] == ped_pkg::OP_PALETTE) &&
                      (32'(entry_idx) < MAX_COLORS);
  assign srch_start = (state_q == ST_ADJ);
  assign out_load   = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // Read the pending below-row error at accept; write back after diffusion.
  assign rs_rd_en   = pix_acc;
  assign rs_wr_en   = ((state_q == ST_WR_PREV) && (cur_col_q != '0)) ||
                      (state_q == ST_WR_LAST);
  assign rs_wr_addr = (state_q == ST_WR_LAST) ? cur_col_q : (cur_col_q - 1'b1);
  always_comb begin
    for (int k = 0; k < ped_pkg::NCH; k++) begin
      rs_wr_data[k*ERR_W +: ERR_W] = (state_q == ST_WR_LAST) ? part0_q[k] : prev_wr_q[k];
    end
  end

  // Past the first row add the below-row error and clamp; add the left error, clamp again.
  always_comb begin
    logic [ERR_W-1:0]   row_e;
    logic signed [10:0] t1;
    logic signed [10:0] t2;
    ped_pkg::pix_t      v1;
    for (int k = 0; k < ped_pkg::NCH; k++) begin
      row_e     = rs_rd_data[k*ERR_W +: ERR_W];
      t1        = $signed({3'b000, px_q[k]}) + $signed({{2{row_e[ERR_W-1]}}, row_e});
      v1        = first_row_q ? px_q[k] : ped_pkg::clamp8(t1);
      t2        = $signed({3'b000, v1}) +
                  $signed({{2{left_q[k][ERR_W-1]}}, left_q[k]});
      px_adj[k] = ped_pkg::clamp8(t2);
    end
  end

  // Split the quantization error into the 7, 3, 5 and 1 sixteenths.
  always_comb begin
    ped_pkg::err_t      err;
    logic signed [12:0] e13;
    ped_pkg::err_t      s3;
    ped_pkg::err_t      s5;
    for (int k = 0; k < ped_pkg::NCH; k++) begin
      err          = $signed({1'b0, px_q[k]}) - $signed({1'b0, pal_q[k]});
      e13          = 13'(err);
      s7[k]        = ped_pkg::div16_tz(e13 * 13'sd7);
      s3           = ped_pkg::div16_tz(e13 * 13'sd3);
      s5           = ped_pkg::div16_tz(e13 * 13'sd5);
      s1[k]        = ped_pkg::div16_tz(e13);
      prev_wr_d[k] = part0_q[k] + s3;
      part0_d[k]   = part1_q[k] + s5;
    end
  end

  // Sequencer, configuration and row tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_valid_q   <= 1'b0;
      psize_q     <= ped_pkg::PSIZE_W'(1);
      lwidth_q    <= ped_pkg::LWIDTH_W'(1024);
      first_row_q <= 1'b1;
      col_q       <= '0;
      for (int k = 0; k < ped_pkg::NCH; k++) begin
        left_q[k]  <= '0;
        part0_q[k] <= '0;
        part1_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ped_pkg::CFG_PALETTE_SIZE: psize_q  <= cfg_data_i[ped_pkg::PSIZE_W-1:0];
          ped_pkg::CFG_LINE_WIDTH:   lwidth_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (pix_acc) begin
            // Frame start restarts at column 0 of a first row.
            if (frame_start) begin
              first_row_q <= 1'b1;
              col_q       <= '0;
              for (int k = 0; k < ped_pkg::NCH; k++) begin
                left_q[k]  <= '0;
                part0_q[k] <= '0;
                part1_q[k] <= '0;
              end
            end
            state_q <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          state_q <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (srch_rsp.done) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          for (int k = 0; k < ped_pkg::NCH; k++) begin
            left_q[k]  <= s7[k];
            part0_q[k] <= part0_d[k];
            part1_q[k] <= s1[k];
          end
          state_q <= ST_WR_PREV;
        end
        ST_WR_PREV: begin
          state_q <= is_last_q ? ST_WR_LAST : ST_OUT;
        end
        ST_WR_LAST: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            // Drop the right and below-right shares at the row end.
            if (is_last_q) begin
              first_row_q <= 1'b0;
              col_q       <= '0;
              for (int k = 0; k < ped_pkg::NCH; k++) begin
                left_q[k]  <= '0;
                part0_q[k] <= '0;
                part1_q[k] <= '0;
              end
            end else begin
              col_q <= cur_col_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      px_q      <= in_pix;
      cur_col_q <= col_eff;
      is_last_q <= (col_eff >= w_last);
    end
    if (state_q == ST_ADJ) begin
      px_q <= px_adj;
    end
    if ((state_q == ST_SEARCH) && srch_rsp.done) begin
      lbl_q <= srch_label;
      pal_q <= srch_rsp.color;
    end
    if (state_q == ST_DIFF) begin
      for (int k = 0; k < ped_pkg::NCH; k++) begin
        prev_wr_q[k] <= prev_wr_d[k];
      end
    end
    if (out_load) begin
      out_lbl_q  <= 4'(lbl_q);
      out_col_q  <= pal_q;
      out_last_q <= is_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_col_q[2], out_col_q[1], out_col_q[0], out_lbl_q};
  assign m_axis_tlast  = out_last_q;

  ped_palette #(
    .MAX_COLORS (MAX_COLORS)
  ) u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (pal_wr_en),
    .wr_addr_i (PIDX_W'(entry_idx)),
    .wr_data_i (in_pix),
    .start_i   (srch_start),
    .count_i   (n_eff),
    .pix_i     (px_q),
    .label_o   (srch_label),
    .rsp_o     (srch_rsp)
  );

  ped_row_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (ped_pkg::ROW_W)
  ) u_row_store (
    .clk_i     (clk_i),
    .rd_en_i   (rs_rd_en),
    .rd_addr_i (col_eff),
    .rd_data_o (rs_rd_data),
    .wr_en_i   (rs_wr_en),
    .wr_addr_i (rs_wr_addr),
    .wr_data_i (rs_wr_data)
  );

  a_pixel_to_adj : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> (state_q == ST_ADJ))
    else $error("accepted pixel did not start processing");

  a_row_rw_apart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rs_wr_en && rs_rd_en))
    else $error("row store read and written in one cycle");

  a_done_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> (state_q == ST_SEARCH))
    else $error("search result outside search state");

  a_row_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_last_q) |=> ((col_q == '0) && !first_row_q))
    else $error("row wrap did not reset column tracking");

endmodule

`default_nettype wire

// ----- dv/palette_error_diffusion_dither_tb.sv -----
`timescale 1ns / 1ps

module palette_error_diffusion_dither_tb;
  import ped_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_WORDS  = 90;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned RX_HOLD_LEN  = 600;

  // One input word and one result word, unpacked into their fields.
  typedef struct {
    logic             op;
    logic [IDX_W-1:0] idx;
    pix3_t            color;        // [0] chan_a, [1] chan_b, [2] chan_c
    logic             frame_start;
  } in_word_t;

  typedef struct {
    logic [IDX_W-1:0] label;
    pix3_t            color;
    logic             row_end;
  } dither_out_t;

  // Tracks palette, error diffusion state and registers; predicts the label
  // and colour of every pixel and checks results in order.
  class dither_scoreboard;
    pix3_t               pal [MAX_COLORS_DEF];
    err_t                row_err [MAX_WIDTH_DEF][NCH];
    bit                  row_written [MAX_WIDTH_DEF];
    int unsigned         column;
    bit                  first_row;
    err_t                left_err [NCH];
    err_t                part_err [2][NCH];
    logic [PSIZE_W-1:0]  pal_size_reg;
    logic [LWIDTH_W-1:0] line_width_reg;
    dither_out_t         expected_colors [$];
    int unsigned         mismatches, results_seen, row_ends, pixels, pal_loads, settings;

    function new();
      pal_size_reg   = 1;
      line_width_reg = 1024;
      first_row      = 1'b1;
      restart_row();
    endfunction

    function void restart_row();
      column = 0;
      for (int k = 0; k < NCH; k++) begin
        left_err[k]    = '0;
        part_err[0][k] = '0;
        part_err[1][k] = '0;
      end
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = line_width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      return w;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PALETTE_SIZE) begin
        pal_size_reg = data[PSIZE_W-1:0];
      end else begin
        line_width_reg = data[LWIDTH_W-1:0];
      end
      settings++;
    endfunction

    // A pixel without frame start reads the row store only past the first row;
    // that entry must have been written already.
    function bit row_safe();
      int unsigned w, c;
      if (first_row) return 1'b1;
      w = eff_width();
      c = (column > w - 1) ? w - 1 : column;
      return row_written[c];
    endfunction

    function int clamp_chan(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function void note_word(in_word_t wd);
      int          px [NCH];
      int          v, diff, err, s3, s5, s1;
      int unsigned n, w, c, best, d, best_d;
      bit          last;
      dither_out_t r;

      if (wd.op == OP_PALETTE) begin
        pal[wd.idx] = wd.color;
        pal_loads++;
        return;
      end
      pixels++;
      if (wd.frame_start) begin
        restart_row();
        first_row = 1'b1;
      end

      n = pal_size_reg;
      if (n == 0) n = 1;
      if (n > MAX_COLORS_DEF) n = MAX_COLORS_DEF;
      w = eff_width();
      c = (column > w - 1) ? w - 1 : column;

      // Past the first row add the below-row error and clamp; then the left error, clamp again.
      for (int k = 0; k < NCH; k++) begin
        v = int'(wd.color[k]);
        if (!first_row) v = clamp_chan(v + row_err[c][k]);
        px[k] = clamp_chan(v + left_err[k]);
      end

      // Least squared distance; a tie keeps the lower entry.
      best   = 0;
      best_d = 0;
      for (int unsigned e = 0; e < n; e++) begin
        d = 0;
        for (int k = 0; k < NCH; k++) begin
          diff = px[k] - int'(pal[e][k]);
          d += diff * diff;
        end
        if (e == 0 || d < best_d) begin
          best_d = d;
          best   = e;
        end
      end

      // Spread 7/16 right, 3/16 below-left, 5/16 below, 1/16 below-right.
      for (int k = 0; k < NCH; k++) begin
        err = px[k] - int'(pal[best][k]);
        s3  = (3 * err) / 16;
        s5  = (5 * err) / 16;
        s1  = err / 16;
        left_err[k] = err_t'((7 * err) / 16);
        if (c > 0) begin
          row_err[c-1][k] = err_t'(part_err[0][k] + s3);
          row_written[c-1] = 1'b1;
        end
        part_err[0][k] = err_t'(part_err[1][k] + s5);
        part_err[1][k] = err_t'(s1);
      end

      last = (c >= w - 1);
      if (last) begin
        for (int k = 0; k < NCH; k++) row_err[c][k] = part_err[0][k];
        row_written[c] = 1'b1;
        restart_row();
        first_row = 1'b0;
      end else begin
        column = c + 1;
      end

      r.label   = best[IDX_W-1:0];
      r.color   = pal[best];
      r.row_end = last;
      expected_colors = {expected_colors, r};
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(dither_out_t got);
      dither_out_t want;
      results_seen++;
      if (got.row_end) row_ends++;
      if (expected_colors.size() == 0) begin
        report($sformatf("result with label %0d arrived with nothing pending", got.label));
        return;
      end
      want = expected_colors.pop_front();
      if (got.label !== want.label)
        report($sformatf("label got %0d want %0d", got.label, want.label));
      for (int k = 0; k < NCH; k++) begin
        if (got.color[k] !== want.color[k])
          report($sformatf("channel %0d got %0d want %0d (label %0d)",
                           k, got.color[k], want.color[k], want.label));
      end
      if (got.row_end !== want.row_end)
        report($sformatf("row end got %0b want %0b", got.row_end, want.row_end));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [TDATA_W-1:0]      s_axis_tdata;
  logic [IN_TUSER_W-1:0]   s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [TDATA_W-1:0]      m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  dither_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold;

  palette_error_diffusion_dither u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #(2_000_000);
    $display("** palette_error_diffusion_dither: FAILED **");
    $finish;
  end

  // Result side: stall at random, or hold off for a whole stretch when asked.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check every result word taken at this edge; values seen here are pre-edge.
  always @(posedge clk_i) begin : result_mon
    dither_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.label   = m_axis_tdata[3:0];
      got.color   = m_axis_tdata[27:4];
      got.row_end = m_axis_tlast;
      sb.check_result(got);
    end
  end

  function automatic in_word_t mk_word(logic op, logic [IDX_W-1:0] idx, pix3_t color,
                                       logic fs);
    in_word_t wd;
    wd.op          = op;
    wd.idx         = idx;
    wd.color       = color;
    wd.frame_start = fs;
    return wd;
  endfunction

  // Lean channel values toward the clamp limits.
  function automatic pix_t rand_chan();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  // Mostly pixels of raster rows; now and then a palette reload or a new frame.
  // Force a frame start where the next pixel would read a row entry never written.
  function automatic in_word_t rand_word();
    in_word_t wd;
    wd.color = {rand_chan(), rand_chan(), rand_chan()};
    wd.idx   = IDX_W'($urandom_range(15));
    if ($urandom_range(99) < 6) begin
      wd.op          = OP_PALETTE;
      wd.frame_start = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) wd.color = sb.pal[$urandom_range(15)];
    end else begin
      wd.op          = OP_PIXEL;
      wd.frame_start = ($urandom_range(99) < 3) || !sb.row_safe();
    end
    return wd;
  endfunction

  // Offer one word and hold it until taken; valid stays high for the next word.
  task automatic send_word(input in_word_t wd);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, wd.color, wd.idx};
    s_axis_tuser  <= {wd.frame_start, wd.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(wd);
  endtask

  // Write both registers back to back; only while the block is idle.
  task automatic set_config(input int ps, input int lw);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_PALETTE_SIZE;
    cfg_data_i  <= CFG_DATA_W'(ps);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(CFG_PALETTE_SIZE, CFG_DATA_W'(ps));
    cfg_index_i <= CFG_LINE_WIDTH;
    cfg_data_i  <= CFG_DATA_W'(lw);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(lw));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every pending result, then let a possible palette write finish.
  task automatic drain();
    while (sb.expected_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : main_seq
    pix3_t dir_px [8];
    int    ps, lw;

    dir_px = '{{8'd10, 8'd10, 8'd10}, {8'd255, 8'd0, 8'd255}, {8'd0, 8'd255, 8'd0},
               {8'd130, 8'd60, 8'd200}, {8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255},
               {8'd128, 8'd128, 8'd128}, {8'd7, 8'd254, 8'd1}};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_PALETTE_SIZE;
    cfg_data_i    <= '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: load all 16 entries, then two rows of four pixels.
    // Entries 0 and 2 sit equally far from (10,10,10): the tie keeps entry 0.
    // Entry 15 duplicates entry 2; a frame start on a palette word is ignored.
    set_config(16, 4);
    send_word(mk_word(OP_PALETTE, 4'd0, {8'd0, 8'd0, 8'd0}, 1'b0));
    send_word(mk_word(OP_PALETTE, 4'd1, {8'd255, 8'd255, 8'd255}, 1'b0));
    send_word(mk_word(OP_PALETTE, 4'd2, {8'd20, 8'd20, 8'd20}, 1'b0));
    send_word(mk_word(OP_PALETTE, 4'd3, {8'd0, 8'd0, 8'd255}, 1'b0));
    send_word(mk_word(OP_PALETTE, 4'd4, {8'd0, 8'd255, 8'd0}, 1'b0));
    send_word(mk_word(OP_PALETTE, 4'd5, {8'd255, 8'd0, 8'd0}, 1'b0));
    for (int e = 6; e < 15; e++)
      send_word(mk_word(OP_PALETTE, IDX_W'(e),
                        {8'(e * 29), 8'(255 - e * 13), 8'(e * 17)}, e == 7));
    send_word(mk_word(OP_PALETTE, 4'd15, {8'd20, 8'd20, 8'd20}, 1'b0));
    for (int i = 0; i < 8; i++)
      send_word(mk_word(OP_PIXEL, 4'd0, dir_px[i], i == 0));
    s_axis_tvalid <= 1'b0;
    drain();

    // Random phases; the first few walk the register extremes, including masked
    // and out-of-range values and a width lowered in the middle of a long row.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin ps = 1;       lw = 1;    end
        1:       begin ps = 'h7E0;   lw = 0;    end
        2:       begin ps = 31;      lw = 2047; end
        3:       begin ps = 16;      lw = 5;    end
        4:       begin ps = 16;      lw = 1024; end
        default: begin ps = $urandom_range(16, 2); lw = $urandom_range(12, 1); end
      endcase
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      set_config(ps, lw);
      // Stall the result side for a long stretch so the input backs up.
      if (p == 6) rx_hold = RX_HOLD_LEN;
      for (int i = 0; i < PHASE_WORDS; i++) send_word(rand_word());
      s_axis_tvalid <= 1'b0;
      drain();
    end

    if (sb.expected_colors.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_colors.size()));
    $display("Run covered %0d pixels and %0d palette loads across %0d register writes",
             sb.pixels, sb.pal_loads, sb.settings);
    $display("Checked %0d results (%0d row ends), %0d mismatches",
             sb.results_seen, sb.row_ends, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** palette_error_diffusion_dither: PASSED **");
    end else begin
      $display("** palette_error_diffusion_dither: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ped_pkg.sv
hdl/ped_row_store.sv
hdl/ped_palette.sv
hdl/palette_error_diffusion_dither.sv
dv/palette_error_diffusion_dither_tb.sv
